// ----- rtl/core/rwrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rwrd_pkg
// Shared types and constants of the weighted range draw block.
// ----------------------------------------------------------------------------
`default_nettype none

package rwrd_pkg;

  localparam int VAL_W = 32;  // range bounds and drawn value
  localparam int WGT_W = 16;  // entry weight
  localparam int RND_W = 31;  // random words
  localparam int IDX_W = 3;   // entry index fields
  localparam int DIV_W = 33;  // divisor / remainder, range width up to 2^32

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [WGT_W-1:0] weight;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/rwrd_ram.sv -----
// ----------------------------------------------------------------------------
// rwrd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rwrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rwrd_div.sv -----
// ----------------------------------------------------------------------------
// rwrd_div
// Restoring radix-2 remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rwrd_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rwrd_pkg::div_req_t req,
  output rwrd_pkg::div_rsp_t      rsp
);

  localparam int CNT_W = $clog2(rwrd_pkg::RND_W + 1);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [rwrd_pkg::RND_W-1:0] dvd_r, dvd_nxt;
  logic [rwrd_pkg::DIV_W-1:0] dsr_r, dsr_nxt;
  logic [rwrd_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [rwrd_pkg::DIV_W:0]   trial;
  logic [rwrd_pkg::DIV_W:0]   diff;

  assign trial = {rem_r, dvd_r[rwrd_pkg::RND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so it fits DIV_W bits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[rwrd_pkg::DIV_W-1:0];
      end else begin
        rem_nxt = trial[rwrd_pkg::DIV_W-1:0];
      end
      dvd_nxt = {dvd_r[rwrd_pkg::RND_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(rwrd_pkg::RND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

`default_nettype wire

// ----- rtl/core/weighted_range_random_draw.sv -----
// ----------------------------------------------------------------------------
// weighted_range_random_draw
// Roulette-wheel draw of a value from a table of weighted value ranges.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): in_tuser selects the item kind, 0 = load, 1 = draw.
//   A load writes one table entry (low, high, weight) and returns nothing. A
//   draw returns one item on the output stream (out_*): the drawn value and
//   chosen entry in out_tdata, an error flag in out_tuser. cfg_* writes
//   range_count (entries below it and below MAX_RANGES take part in a draw).
// Draw steps:
//   A draw sums the weights of entries 0..n-1 (n = range_count capped at
//   MAX_RANGES), takes the pick word's remainder on one shared bit-serial
//   divider, walks the running sum to the first entry that passes it, checks
//   that entry's range, takes the value word's remainder on the same divider
//   and loads the output register. One draw is in work at a time; in_tready
//   returns as the result enters the output register. A zero total or an
//   empty range gives value 0, out_tuser 1.
// Reset: range_count returns to 1, no result pending. Table contents are
//   undefined until loaded; no clearing pass runs.
// Stall: a finished result sits in the output register; new items are taken
//   meanwhile, and the next draw waits at its end until that register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_range_random_draw #(
  parameter int MAX_RANGES = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data,     // range_count
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [2:0] entry_index, [34:3] low_value, [66:35] high_value,
  // [82:67] entry_weight, [113:83] pick_random, [144:114] value_random
  input  wire logic [151:0] in_tdata,
  input  wire logic [0:0]   in_tuser,     // [0] operation
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic      [39:0]  out_tdata,    // [31:0] drawn_value, [34:32] chosen_entry
  output logic      [0:0]   out_tuser     // [0] draw_error
);

  localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int NW = $clog2(MAX_RANGES + 1);
  localparam int SW = rwrd_pkg::WGT_W + NW;
  localparam int VW = rwrd_pkg::VAL_W;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_SUM      = 7'b0000010,
    ST_DIV_PICK = 7'b0000100,
    ST_WALK     = 7'b0001000,
    ST_CHECK    = 7'b0010000,
    ST_DIV_VAL  = 7'b0100000,
    ST_FINISH   = 7'b1000000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [3:0]                 range_count_r, range_count_nxt;
  logic [NW-1:0]              n_w;
  logic [NW-1:0]              rd_idx_r, rd_idx_nxt;
  logic                       dvld_r, dvld_nxt;
  logic [AW-1:0]              data_idx_r, data_idx_nxt;
  logic [SW-1:0]              total_r, total_nxt;
  logic [SW-1:0]              acc_r, acc_nxt;
  logic [SW-1:0]              acc_sum;
  logic [SW-1:0]              pick_r, pick_nxt;
  logic [rwrd_pkg::RND_W-1:0] pick_rnd_r, pick_rnd_nxt;
  logic [rwrd_pkg::RND_W-1:0] val_rnd_r, val_rnd_nxt;
  logic [VW-1:0]              lo_r, lo_nxt;
  logic [VW-1:0]              hi_r, hi_nxt;
  logic [AW-1:0]              chosen_r, chosen_nxt;
  logic [VW-1:0]              res_val_r, res_val_nxt;
  logic [rwrd_pkg::IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic                       res_err_r, res_err_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [VW-1:0]              out_val_r, out_val_nxt;
  logic [rwrd_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic                       out_err_r, out_err_nxt;
  logic [VW+1:0]              range_wid;

  logic                       in_fire;
  logic                       rd_en;
  logic                       ram_we;
  rwrd_pkg::entry_t           ram_wdata;
  rwrd_pkg::entry_t           ram_rdata;
  rwrd_pkg::div_req_t         div_req;
  rwrd_pkg::div_rsp_t         div_rsp;

  logic [rwrd_pkg::IDX_W-1:0] in_entry_index;
  logic [rwrd_pkg::RND_W-1:0] in_pick_random;
  logic [rwrd_pkg::RND_W-1:0] in_value_random;

  assign in_entry_index   = in_tdata[2:0];
  assign ram_wdata.lo     = in_tdata[34:3];
  assign ram_wdata.hi     = in_tdata[66:35];
  assign ram_wdata.weight = in_tdata[82:67];
  assign in_pick_random   = in_tdata[113:83];
  assign in_value_random  = in_tdata[144:114];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign ram_we    = in_fire && (in_tuser[0] == rwrd_pkg::OP_LOAD) &&
                     (int'(in_entry_index) < MAX_RANGES);

  // entries beyond the table take no part
  always_comb begin
    if (int'(range_count_r) > MAX_RANGES) begin
      n_w = NW'(MAX_RANGES);
    end else begin
      n_w = NW'(range_count_r);
    end
  end

  assign rd_en     = ((state_r == ST_SUM) || (state_r == ST_WALK)) && (rd_idx_r < n_w);
  assign acc_sum   = acc_r + SW'(ram_rdata.weight);
  assign range_wid = {{2{hi_r[VW-1]}}, hi_r} - {{2{lo_r[VW-1]}}, lo_r} + (VW+2)'(1);

  rwrd_ram #(
    .WIDTH (rwrd_pkg::ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  rwrd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt        = state_r;
    range_count_nxt  = range_count_r;
    rd_idx_nxt       = rd_idx_r;
    dvld_nxt         = rd_en;
    data_idx_nxt     = rd_idx_r[AW-1:0];
    total_nxt        = total_r;
    acc_nxt          = acc_r;
    pick_nxt         = pick_r;
    pick_rnd_nxt     = pick_rnd_r;
    val_rnd_nxt      = val_rnd_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    chosen_nxt       = chosen_r;
    res_val_nxt      = res_val_r;
    res_idx_nxt      = res_idx_r;
    res_err_nxt      = res_err_r;
    out_valid_nxt    = out_valid_r && !out_tready;
    out_val_nxt      = out_val_r;
    out_idx_nxt      = out_idx_r;
    out_err_nxt      = out_err_r;
    div_req.start    = 1'b0;
    div_req.dividend = pick_rnd_r;
    div_req.divisor  = rwrd_pkg::DIV_W'(total_r);

    if (cfg_valid && cfg_ready) begin
      range_count_nxt = cfg_data;
    end
    if (rd_en) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser[0] == rwrd_pkg::OP_DRAW)) begin
          pick_rnd_nxt = in_pick_random;
          val_rnd_nxt  = in_value_random;
          total_nxt    = '0;
          rd_idx_nxt   = '0;
          state_nxt    = ST_SUM;
        end
      end
      ST_SUM: begin
        if (dvld_r) begin
          total_nxt = total_r + SW'(ram_rdata.weight);
        end
        if (!rd_en && !dvld_r) begin
          if (total_r == '0) begin
            res_val_nxt = '0;
            res_idx_nxt = '0;
            res_err_nxt = 1'b1;
            state_nxt   = ST_FINISH;
          end else begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV_PICK;
          end
        end
      end
      ST_DIV_PICK: begin
        if (div_rsp.done) begin
          pick_nxt   = SW'(div_rsp.rem);
          acc_nxt    = '0;
          rd_idx_nxt = '0;
          state_nxt  = ST_WALK;
        end
      end
      ST_WALK: begin
        // first entry whose running sum passes the pick
        if (dvld_r) begin
          acc_nxt = acc_sum;
          if (acc_sum > pick_r) begin
            lo_nxt     = ram_rdata.lo;
            hi_nxt     = ram_rdata.hi;
            chosen_nxt = data_idx_r;
            state_nxt  = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        res_idx_nxt = rwrd_pkg::IDX_W'(chosen_r);
        if (range_wid[VW+1] || (range_wid == '0)) begin
          res_val_nxt = '0;
          res_err_nxt = 1'b1;
          state_nxt   = ST_FINISH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = val_rnd_r;
          div_req.divisor  = range_wid[rwrd_pkg::DIV_W-1:0];
          state_nxt        = ST_DIV_VAL;
        end
      end
      ST_DIV_VAL: begin
        if (div_rsp.done) begin
          res_val_nxt = lo_r + div_rsp.rem[VW-1:0];
          res_err_nxt = 1'b0;
          state_nxt   = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_idx_nxt   = res_idx_r;
          out_err_nxt   = res_err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      range_count_r <= 4'd1;
      rd_idx_r      <= '0;
      dvld_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      range_count_r <= range_count_nxt;
      rd_idx_r      <= rd_idx_nxt;
      dvld_r        <= dvld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_idx_r <= data_idx_nxt;
    total_r    <= total_nxt;
    acc_r      <= acc_nxt;
    pick_r     <= pick_nxt;
    pick_rnd_r <= pick_rnd_nxt;
    val_rnd_r  <= val_rnd_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    chosen_r   <= chosen_nxt;
    res_val_r  <= res_val_nxt;
    res_idx_r  <= res_idx_nxt;
    res_err_r  <= res_err_nxt;
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {5'b0, out_idx_r, out_val_r};
  assign out_tuser[0] = out_err_r;

  // a new result only comes from the end of a draw
  a_out_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_FINISH))
    else $error("result appeared outside the end of a draw");

  // the shared divider is never restarted mid-operation
  a_div_no_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // an errored draw carries a zero value
  a_err_zero_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[31:0] == '0))
    else $error("error result with nonzero value");

endmodule

`default_nettype wire

// ----- tb/sv/tb_weighted_range_random_draw.sv -----
// ----------------------------------------------------------------------------
// tb_weighted_range_random_draw
// Self-checking bench for the weighted range draw block. Loads fill the range
// table and draws are predicted from a local copy of the table and of
// range_count. The random phases vary the input gaps and output back-pressure,
// and one phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_weighted_range_random_draw;

  localparam int TABLE_DEPTH  = 8;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE       = 40;    // margin for loads to finish
  localparam int TAIL_CYCLES  = 200;   // more than one draw's latency
  localparam int HOLD_CYCLES  = 1500;
  localparam int NUM_PHASES   = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  entry;
    logic        err;
  } draw_result_t;

  // Tracks the range table and range_count. Holds the expected draw results.
  class range_draw_tracker;
    logic signed [31:0] low_tab[TABLE_DEPTH];
    logic signed [31:0] high_tab[TABLE_DEPTH];
    logic [15:0]        weight_tab[TABLE_DEPTH];
    logic [3:0]         count;
    draw_result_t       pending[$];
    int                 errors;

    function new();
      count  = 4'd1;
      errors = 0;
    endfunction

    function void set_count(logic [3:0] v);
      count = v;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    function draw_result_t predict_draw(logic [30:0] pick_word, logic [30:0] value_word);
      int unsigned  n, total, pk, acc, chosen;
      bit           found;
      longint       lo, hi, span;
      draw_result_t r;
      n = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
      total = 0;
      for (int k = 0; k < n; k++) total += weight_tab[k];
      r.value = '0;
      r.entry = '0;
      r.err   = 1'b1;
      if (total == 0) return r;
      pk = pick_word % total;
      acc = 0;
      chosen = 0;
      found = 1'b0;
      // first entry whose running sum passes the pick
      for (int k = 0; k < n; k++) begin
        acc += weight_tab[k];
        if (!found && acc > pk) begin
          chosen = k;
          found = 1'b1;
        end
      end
      lo = low_tab[chosen];
      hi = high_tab[chosen];
      span = hi - lo + 1;
      r.entry = 3'(chosen);
      if (span <= 0) return r;
      r.value = 32'(lo + longint'(value_word) % span);
      r.err   = 1'b0;
      return r;
    endfunction

    function void note_item(logic op, logic [151:0] d);
      int idx;
      if (op == rwrd_pkg::OP_LOAD) begin
        idx = d[2:0];
        low_tab[idx]    = d[34:3];
        high_tab[idx]   = d[66:35];
        weight_tab[idx] = d[82:67];
      end else begin
        pending.insert(pending.size(), predict_draw(d[113:83], d[144:114]));
      end
    endfunction

    function void check_result(logic [39:0] tdata, logic [0:0] tuser);
      draw_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] result with no draw pending: value %0d entry %0d err %0b",
                   $realtime, $signed(tdata[31:0]), tdata[34:32], tuser[0]);
        return;
      end
      exp_r = pending.pop_front();
      if (tdata[31:0] !== exp_r.value || tdata[34:32] !== exp_r.entry ||
          tuser[0] !== exp_r.err) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"[%0t] draw mismatch: value exp %0d got %0d, ",
                    "entry exp %0d got %0d, err exp %0b got %0b"},
                   $realtime, $signed(exp_r.value), $signed(tdata[31:0]),
                   exp_r.entry, tdata[34:32], exp_r.err, tuser[0]);
      end
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        $display("%0d draw results never arrived", pending.size());
        errors += pending.size();
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [39:0]  out_tdata;
  logic [0:0]   out_tuser;

  range_draw_tracker tracker = new();
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_request   = 1'b0;
  int cycle_count    = 0;

  weighted_range_random_draw uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // accepted items, config writes and results
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) tracker.set_count(cfg_data);
    if (rst_n && in_tvalid && in_tready) tracker.note_item(in_tuser[0], in_tdata);
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata, out_tuser);
  end

  // output back-pressure; a hold request blocks the output for a long stretch
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic put_item(input logic op, input logic [151:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  // draw fields carry junk on a load
  task automatic send_load(input logic [2:0] idx, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [15:0] w);
    put_item(rwrd_pkg::OP_LOAD, {7'b0, 31'($urandom), 31'($urandom), w, hi, lo, idx});
  endtask

  // load fields carry junk on a draw
  task automatic send_draw(input logic [30:0] pick, input logic [30:0] vr);
    put_item(rwrd_pkg::OP_DRAW, {7'b0, vr, pick, 16'($urandom), 32'($urandom),
                                 32'($urandom), 3'($urandom)});
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_range_count(input logic [3:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int          phase_count[NUM_PHASES] = '{8, 3, 15, 1, 6, 8, 2, 0};
    int          n_items;
    logic [2:0]  idx;
    logic [31:0] lo, hi;
    logic [15:0] w;
    logic [30:0] pick, vr;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every entry loaded before any draw
    send_load(3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);  // full 2^32 span
    send_load(3'd1, 32'd5, 32'd5, 16'd1);                     // single value
    send_load(3'd2, 32'd10, 32'd3, 16'd100);                  // empty range
    send_load(3'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0);     // never chosen
    send_load(3'd4, -32'sd100, 32'd100, 16'h8000);
    send_load(3'd5, 32'd0, 32'h7FFF_FFFF, 16'd7);
    send_load(3'd6, 32'h8000_0000, 32'h8000_0009, 16'd1);
    send_load(3'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFE, 16'hFFFF);
    // range_count still at reset value
    send_draw(31'd0, 31'd0);
    send_draw('1, '1);

    wait_drained();
    write_range_count(4'd8);
    send_draw(31'd65535, 31'd7);    // last pick of entry 1
    send_draw(31'd65536, 31'd7);    // lands on the empty range
    send_draw(31'd65636, 31'd9);    // skips the zero weight
    send_draw(31'd163946, '1);      // last entry
    send_draw('1, 31'd12345);

    wait_drained();
    write_range_count(4'd0);        // nothing takes part
    send_draw(31'd3, 31'd3);

    wait_drained();
    write_range_count(4'd15);       // saturates to the table depth
    send_draw('1, '1);
    send_draw(31'($urandom), 31'($urandom));

    wait_drained();
    write_range_count(4'd1);
    send_load(3'd0, 32'd1, 32'd2, 16'd0);  // total weight zero
    send_draw(31'd0, 31'd0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_range_count(4'(phase_count[ph]));
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct = 24;
          recv_stall_pct = 24;
        end
      endcase
      n_items = (phase_count[ph] == 0) ? 24 : 80;
      // back-to-back draws into a blocked output fill the block
      if (ph == 4) begin
        hold_request = 1'b1;
        repeat (30) send_draw(31'($urandom), 31'($urandom));
      end
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(99) < 30) begin
          idx = 3'($urandom_range(TABLE_DEPTH - 1));
          lo = $urandom;
          case ($urandom_range(4))
            0: hi = $urandom;
            1: hi = lo + $urandom_range(15);
            2: begin
              lo = 32'h8000_0000;
              hi = 32'h7FFF_FFFF;
            end
            3: hi = lo - 1 - $urandom_range(3);
            default: hi = lo;
          endcase
          case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2, 3, 4: w = 16'($urandom_range(1, 10));
            default: w = 16'($urandom);
          endcase
          send_load(idx, lo, hi, w);
        end else begin
          case ($urandom_range(5))
            0: pick = '0;
            1: pick = '1;
            2: pick = 31'($urandom_range(200000));
            default: pick = 31'($urandom);
          endcase
          case ($urandom_range(4))
            0: vr = '0;
            1: vr = '1;
            default: vr = 31'($urandom);
          endcase
          send_draw(pick, vr);
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/rwrd_pkg.sv
rtl/core/rwrd_ram.sv
rtl/core/rwrd_div.sv
rtl/core/weighted_range_random_draw.sv
tb/sv/tb_weighted_range_random_draw.sv
